@@ rtl/fte_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Four-tap feedback echo: shared definitions
// Sizes, register indexes, the frame record and the sequencer states that
// the echo front queue, the engine and the channel interfaces have in common.
// ----------------------------------------------------------------------------
package fte_pkg;

  // Storage and datapath sizes.
  localparam int MAX_DELAY_FRAMES = 32768;
  localparam int TAP_COUNT        = 4;
  localparam int SAMPLE_BITS      = 16;

  localparam int ADDR_W       = $clog2(MAX_DELAY_FRAMES);
  localparam int LEN_W        = $clog2(MAX_DELAY_FRAMES + 1);
  localparam int GAIN_BITS    = 16;
  localparam int NUM_TAP_REGS = 4;
  localparam int GAIN_REG_W   = GAIN_BITS * NUM_TAP_REGS;
  localparam int DELAY_REG_W  = 16;
  localparam int CFG_DATA_W   = 64;
  localparam int CFG_IDX_W    = 3;
  localparam int NUM_CH       = 2;
  localparam int QUEUE_DEPTH  = 2;

  // Fraction bits removed when rounding the echo sum and the feedback term.
  localparam int OUT_FRAC = 14;
  localparam int FB_FRAC  = 28;

  // Delay length after reset, in frames.
  localparam int DELAY_RESET = 4800;

  // Saturation limits of one sample.
  localparam int SAT_MAX = (2 ** (SAMPLE_BITS - 1)) - 1;
  localparam int SAT_MIN = -(2 ** (SAMPLE_BITS - 1));

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TAP_GAINS = 3'd0,
    REG_FEEDBACK  = 3'd1,
    REG_DELAY_0   = 3'd2,
    REG_DELAY_1   = 3'd3,
    REG_DELAY_2   = 3'd4,
    REG_DELAY_3   = 3'd5
  } cfg_reg_e;

  // One stereo frame as held in the front queue.
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left;
    logic signed [SAMPLE_BITS-1:0] right;
    logic                          block_end;
  } frame_t;

  // Engine sequencer states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MULT,
    ST_SUM,
    ST_FBMUL,
    ST_WRITE
  } eng_state_e;

endpackage
`default_nettype wire

@@ rtl/fte_frame_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Frame input channel
// Valid/ready channel carrying one stereo frame and its block end mark.
// ----------------------------------------------------------------------------
interface fte_frame_if;
  import fte_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_in;
  logic signed [SAMPLE_BITS-1:0] right_in;
  logic                          block_end;

  modport source (output valid, output left_in, output right_in, output block_end,
                  input ready);
  modport sink   (input valid, input left_in, input right_in, input block_end,
                  output ready);
endinterface
`default_nettype wire

@@ rtl/fte_result_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Result output channel
// Valid/ready channel carrying one processed stereo frame and its flags.
// ----------------------------------------------------------------------------
interface fte_result_if;
  import fte_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_out;
  logic signed [SAMPLE_BITS-1:0] right_out;
  logic                          clipped;
  logic                          block_end_out;

  modport source (output valid, output left_out, output right_out, output clipped,
                  output block_end_out, input ready);
  modport sink   (input valid, input left_out, input right_out, input clipped,
                  input block_end_out, output ready);
endinterface
`default_nettype wire

@@ rtl/fte_cfg_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying a register index and its write data.
// ----------------------------------------------------------------------------
interface fte_cfg_if;
  import fte_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/four_tap_feedback_echo.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Four-tap feedback echo
// Stereo echo over four circular delay lines with per-tap gains and a
// common feedback gain; sums saturate and report clipping.
//
//   Channel   Dir  Handshake       Payload
//   frame_i   in   valid / ready   left_in, right_in, block_end
//   result_o  out  valid / ready   left_out, right_out, clipped, block_end_out
//   cfg_i     in   valid / ready   index, data (ready always high)
//
// Each frame passes through the engine sequencer steps in order: memory read,
// tap multiply, tap sum, feedback multiply, write back.
// After reset a sweep zeroes every entry of the four line memories; frame_i
// holds ready low until it ends, while configuration writes are taken.
// A two-entry front queue takes frames while the engine is busy, and the
// result register lets the engine run the next frame up to write back while
// a result waits.
// ----------------------------------------------------------------------------
module four_tap_feedback_echo (
  input  logic        clk_i,
  input  logic        rst_ni,
  fte_frame_if.sink   frame_i,
  fte_result_if.source result_o,
  fte_cfg_if.sink     cfg_i
);
  import fte_pkg::*;

  logic   q_valid;
  frame_t q_item;
  logic   q_pop;
  logic   accept_en;

  // Front queue.
  fte_in_queue u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .frame_i     (frame_i),
    .accept_en_i (accept_en),
    .q_valid_o   (q_valid),
    .q_item_o    (q_item),
    .q_pop_i     (q_pop)
  );

  // Processing engine.
  fte_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .accept_en_o (accept_en),
    .cfg_i       (cfg_i),
    .result_o    (result_o)
  );

endmodule
`default_nettype wire

@@ rtl/fte_echo_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Echo line memory
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module fte_echo_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port, data registered.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

@@ rtl/fte_in_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Echo front queue
// Takes frames from the input channel into a short FIFO so that the input
// side and the processing engine stall independently.
// ----------------------------------------------------------------------------
module fte_in_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  fte_frame_if.sink       frame_i,
  input  logic            accept_en_i,
  output logic            q_valid_o,
  output fte_pkg::frame_t q_item_o,
  input  logic            q_pop_i
);
  import fte_pkg::*;

  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

  frame_t            slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              push;
  logic              pop;
  frame_t            in_item;

  // Handshake and incoming record.
  always_comb begin
    frame_i.ready     = accept_en_i && (count_q < CNT_W'(QUEUE_DEPTH));
    push              = frame_i.valid && frame_i.ready;
    pop               = q_pop_i && (count_q != '0);
    in_item.left      = frame_i.left_in;
    in_item.right     = frame_i.right_in;
    in_item.block_end = frame_i.block_end;
  end

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Frame storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= in_item;
    end
  end

  assign q_valid_o = (count_q != '0);
  assign q_item_o  = slot_q[rd_ptr_q];

endmodule
`default_nettype wire

@@ rtl/fte_engine.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Echo engine
// Holds the configuration registers, the delay line memories and their
// positions, and runs one frame at a time through read, tap multiply, sum,
// feedback multiply and write back, ending in the result output register.
// ----------------------------------------------------------------------------
module fte_engine (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  input  fte_pkg::frame_t q_item_i,
  output logic            q_pop_o,
  output logic            accept_en_o,
  fte_cfg_if.sink         cfg_i,
  fte_result_if.source    result_o
);
  import fte_pkg::*;

  localparam int PROD_W   = SAMPLE_BITS + GAIN_BITS;
  localparam int SUM_W    = PROD_W + $clog2(TAP_COUNT) + 1;
  localparam int FB_W     = SUM_W + GAIN_BITS;
  localparam int RS_W     = SUM_W + 1;
  localparam int FBR_W    = FB_W + 1;
  localparam int SAT_IN_W = FBR_W + 1;
  localparam int WORD_W   = NUM_CH * SAMPLE_BITS;

  localparam logic signed [RS_W-1:0]  OUT_HALF = RS_W'(1) <<< (OUT_FRAC - 1);
  localparam logic signed [FBR_W-1:0] FB_HALF  = FBR_W'(1) <<< (FB_FRAC - 1);

  // Saturate to one sample; the top bit of the result flags clipping.
  function automatic logic [SAMPLE_BITS:0] sat_fn(input logic signed [SAT_IN_W-1:0] v);
    logic signed [SAT_IN_W-1:0] hi;
    logic signed [SAT_IN_W-1:0] lo;
    hi = SAT_IN_W'(SAT_MAX);
    lo = SAT_IN_W'(SAT_MIN);
    if (v > hi) begin
      return {1'b1, SAMPLE_BITS'(SAT_MAX)};
    end else if (v < lo) begin
      return {1'b1, SAMPLE_BITS'(SAT_MIN)};
    end
    return {1'b0, v[SAMPLE_BITS-1:0]};
  endfunction

  // Configuration registers.
  logic [GAIN_REG_W-1:0]         tap_gains_q;
  logic signed [GAIN_BITS-1:0]   fb_gain_q;
  logic [DELAY_REG_W-1:0]        delay_q [NUM_TAP_REGS];
  logic                          cfg_fire;
  logic [NUM_TAP_REGS-1:0]       cfg_delay_wr;

  // Sequencer and clearing pass.
  eng_state_e                    state_q, state_d;
  logic [ADDR_W-1:0]             clr_cnt_q, clr_cnt_d;
  logic                          clearing;
  logic                          clr_last;
  logic                          write_fire;
  logic                          out_free;

  // Line positions.
  logic [ADDR_W-1:0]             pos_q   [TAP_COUNT];
  logic [ADDR_W-1:0]             pos_nxt [TAP_COUNT];
  logic [LEN_W-1:0]              eff_len [TAP_COUNT];

  // Memory ports.
  logic [WORD_W-1:0]             rd_data [TAP_COUNT];
  logic [ADDR_W-1:0]             ram_waddr;
  logic [WORD_W-1:0]             ram_wdata;
  logic                          ram_we;

  // Datapath stages.
  logic signed [SAMPLE_BITS-1:0] x_q      [NUM_CH];
  logic                          be_q;
  logic signed [PROD_W-1:0]      prod_q   [TAP_COUNT][NUM_CH];
  logic signed [PROD_W-1:0]      prod_d   [TAP_COUNT][NUM_CH];
  logic signed [SUM_W-1:0]       sum_q    [NUM_CH];
  logic signed [SUM_W-1:0]       sum_d    [NUM_CH];
  logic signed [FB_W-1:0]        fbp_q    [NUM_CH];
  logic signed [FB_W-1:0]        fbp_d    [NUM_CH];
  logic signed [SAMPLE_BITS-1:0] res_q    [NUM_CH];
  logic [SAMPLE_BITS:0]          res_sat  [NUM_CH];
  logic                          res_clip_q;
  logic [SAMPLE_BITS:0]          wb_sat   [NUM_CH];
  logic                          wb_clip;

  // Output register.
  logic                          out_valid_q;
  logic signed [SAMPLE_BITS-1:0] out_left_q;
  logic signed [SAMPLE_BITS-1:0] out_right_q;
  logic                          out_clip_q;
  logic                          out_be_q;

  // ---------------------------------------------------------------- config

  // Writes are always taken; a delay write restarts that line's position.
  always_comb begin
    cfg_i.ready = 1'b1;
    cfg_fire    = cfg_i.valid && cfg_i.ready;
    for (int k = 0; k < NUM_TAP_REGS; k++) begin
      cfg_delay_wr[k] = cfg_fire &&
                        (cfg_i.index == CFG_IDX_W'(int'(REG_DELAY_0) + k));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_gains_q <= '0;
      fb_gain_q   <= '0;
      for (int k = 0; k < NUM_TAP_REGS; k++) begin
        delay_q[k] <= DELAY_REG_W'(DELAY_RESET);
      end
    end else if (cfg_fire) begin
      case (cfg_reg_e'(cfg_i.index))
        REG_TAP_GAINS: tap_gains_q <= cfg_i.data[GAIN_REG_W-1:0];
        REG_FEEDBACK:  fb_gain_q   <= cfg_i.data[GAIN_BITS-1:0];
        REG_DELAY_0:   delay_q[0]  <= cfg_i.data[DELAY_REG_W-1:0];
        REG_DELAY_1:   delay_q[1]  <= cfg_i.data[DELAY_REG_W-1:0];
        REG_DELAY_2:   delay_q[2]  <= cfg_i.data[DELAY_REG_W-1:0];
        REG_DELAY_3:   delay_q[3]  <= cfg_i.data[DELAY_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------- sequencer

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid_i) begin
          state_d = ST_MULT;
        end
      end
      ST_MULT:  state_d = ST_SUM;
      ST_SUM:   state_d = ST_FBMUL;
      ST_FBMUL: state_d = ST_WRITE;
      ST_WRITE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    out_free    = !out_valid_q || result_o.ready;
    clearing    = (state_q == ST_CLEAR);
    clr_last    = (clr_cnt_q == ADDR_W'(MAX_DELAY_FRAMES - 1));
    accept_en_o = !clearing;
    q_pop_o     = (state_q == ST_IDLE) && q_valid_i;
    write_fire  = (state_q == ST_WRITE) && out_free;
    clr_cnt_d   = clearing ? clr_cnt_q + 1'b1 : clr_cnt_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
    end
  end

  // ------------------------------------------------------------- positions

  // Effective line length and the position after this frame.
  always_comb begin
    for (int k = 0; k < TAP_COUNT; k++) begin
      logic [LEN_W:0] nxt;
      if (delay_q[k] == '0) begin
        eff_len[k] = LEN_W'(1);
      end else if (32'(delay_q[k]) > 32'(MAX_DELAY_FRAMES)) begin
        eff_len[k] = LEN_W'(MAX_DELAY_FRAMES);
      end else begin
        eff_len[k] = LEN_W'(delay_q[k]);
      end
      nxt        = (LEN_W + 1)'(pos_q[k]) + 1'b1;
      pos_nxt[k] = (nxt >= (LEN_W + 1)'(eff_len[k])) ? '0 : nxt[ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < TAP_COUNT; k++) begin
        pos_q[k] <= '0;
      end
    end else begin
      for (int k = 0; k < TAP_COUNT; k++) begin
        if (cfg_delay_wr[k]) begin
          pos_q[k] <= '0;
        end else if (write_fire) begin
          pos_q[k] <= pos_nxt[k];
        end
      end
    end
  end

  // -------------------------------------------------------------- memories

  // All lines share write enable and data; the clearing sweep shares one address, write back uses each line's own.
  always_comb begin
    ram_we    = clearing || write_fire;
    ram_waddr = clr_cnt_q;
    ram_wdata = {wb_sat[1][SAMPLE_BITS-1:0], wb_sat[0][SAMPLE_BITS-1:0]};
    if (clearing) begin
      ram_wdata = '0;
    end
  end

  for (genvar k = 0; k < TAP_COUNT; k++) begin : g_line
    fte_echo_ram #(
      .DEPTH (MAX_DELAY_FRAMES),
      .WIDTH (WORD_W)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (ram_we),
      .waddr_i (clearing ? ram_waddr : pos_q[k]),
      .wdata_i (ram_wdata),
      .raddr_i (pos_q[k]),
      .rdata_o (rd_data[k])
    );
  end

  // -------------------------------------------------------------- datapath

  // Tap products, one per tap and channel.
  always_comb begin
    for (int k = 0; k < TAP_COUNT; k++) begin
      logic signed [GAIN_BITS-1:0]   g;
      logic signed [SAMPLE_BITS-1:0] s;
      g = tap_gains_q[k*GAIN_BITS +: GAIN_BITS];
      for (int c = 0; c < NUM_CH; c++) begin
        s            = rd_data[k][c*SAMPLE_BITS +: SAMPLE_BITS];
        prod_d[k][c] = PROD_W'(s) * PROD_W'(g);
      end
    end
  end

  // Sum of the tap products.
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      logic signed [SUM_W-1:0] acc;
      acc = '0;
      for (int k = 0; k < TAP_COUNT; k++) begin
        acc = acc + SUM_W'(prod_q[k][c]);
      end
      sum_d[c] = acc;
    end
  end

  // Feedback product and the rounded, saturated output sample.
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      logic signed [RS_W-1:0] rnd;
      fbp_d[c]   = FB_W'(sum_q[c]) * FB_W'(fb_gain_q);
      rnd        = (RS_W'(sum_q[c]) + OUT_HALF) >>> OUT_FRAC;
      res_sat[c] = sat_fn(SAT_IN_W'(x_q[c]) + SAT_IN_W'(rnd));
    end
  end

  // Rounded, saturated value written back into the lines.
  always_comb begin
    wb_clip = 1'b0;
    for (int c = 0; c < NUM_CH; c++) begin
      logic signed [FBR_W-1:0] fbr;
      fbr       = (FBR_W'(fbp_q[c]) + FB_HALF) >>> FB_FRAC;
      wb_sat[c] = sat_fn(SAT_IN_W'(x_q[c]) + SAT_IN_W'(fbr));
      wb_clip   = wb_clip | wb_sat[c][SAMPLE_BITS];
    end
  end

  // Stage registers, each loaded in its own sequencer step.
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      x_q[0] <= q_item_i.left;
      x_q[1] <= q_item_i.right;
      be_q   <= q_item_i.block_end;
    end
    if (state_q == ST_MULT) begin
      prod_q <= prod_d;
    end
    if (state_q == ST_SUM) begin
      sum_q <= sum_d;
    end
    if (state_q == ST_FBMUL) begin
      fbp_q      <= fbp_d;
      res_q[0]   <= res_sat[0][SAMPLE_BITS-1:0];
      res_q[1]   <= res_sat[1][SAMPLE_BITS-1:0];
      res_clip_q <= res_sat[0][SAMPLE_BITS] | res_sat[1][SAMPLE_BITS];
    end
  end

  // --------------------------------------------------------- result output

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (write_fire) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (write_fire) begin
      out_left_q  <= res_q[0];
      out_right_q <= res_q[1];
      out_clip_q  <= res_clip_q | wb_clip;
      out_be_q    <= be_q;
    end
  end

  assign result_o.valid         = out_valid_q;
  assign result_o.left_out      = out_left_q;
  assign result_o.right_out     = out_right_q;
  assign result_o.clipped       = out_clip_q;
  assign result_o.block_end_out = out_be_q;

  // ------------------------------------------------------------ assertions

  a_no_pop_while_clearing : assert property (
    @(posedge clk_i) disable iff (!rst_ni) clearing |-> !q_pop_o
  ) else $error("frame taken from the queue during the clearing sweep");

  a_no_result_overwrite : assert property (
    @(posedge clk_i) disable iff (!rst_ni) write_fire |-> (!out_valid_q || result_o.ready)
  ) else $error("result register loaded while an untaken result waits");

  a_result_after_write : assert property (
    @(posedge clk_i) disable iff (!rst_ni) write_fire |=> out_valid_q
  ) else $error("write back completed without presenting a result");

  a_pos_in_range : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      (LEN_W'(pos_q[0]) < eff_len[0]) && (LEN_W'(pos_q[TAP_COUNT-1]) < eff_len[TAP_COUNT-1])
  ) else $error("line position at or beyond its length");

endmodule
`default_nettype wire

@@ sim/four_tap_feedback_echo_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Four-tap feedback echo testbench
// Streams stereo frames through the echo over its valid/ready channels and
// compares every result with an in-bench predictor of the four delay lines.
// A short directed part covers sample extremes, saturation, the half-way
// rounding points and the reset register values. Random phases follow with
// fresh gains and line lengths, including zero and oversized lengths.
// ----------------------------------------------------------------------------
module four_tap_feedback_echo_test;
  import fte_pkg::*;

  localparam int ROUNDS        = 10;
  localparam int PER_ROUND     = 135;
  localparam int SETTLE_CYCLES = 12;
  localparam int REPORT_CAP    = 30;

  // Register indexes that no register answers to.
  localparam logic [CFG_IDX_W-1:0] UNMAPPED_REG_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] UNMAPPED_REG_HI = 3'd7;

  // One processed frame as seen on the result channel.
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left;
    logic signed [SAMPLE_BITS-1:0] right;
    logic                          clipped;
    logic                          block_end;
  } echo_out_t;

  // One frame waiting to be sent; drain_first holds it back until the
  // block has delivered every outstanding result.
  typedef struct {
    frame_t frame;
    bit     drain_first;
  } frame_job_t;

  logic clk;
  logic rst_n;

  fte_frame_if  frame_ch ();
  fte_result_if result_ch ();
  fte_cfg_if    cfg_ch ();

  four_tap_feedback_echo uut (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .frame_i  (frame_ch),
    .result_o (result_ch),
    .cfg_i    (cfg_ch)
  );

  // Predictor state: registers, line pointers and the delay line contents.
  logic [GAIN_REG_W-1:0]         tap_gain_word;
  logic signed [GAIN_BITS-1:0]   feedback_q14;
  logic [DELAY_REG_W-1:0]        line_len_reg [TAP_COUNT];
  logic [ADDR_W-1:0]             line_ptr [TAP_COUNT];
  bit signed [SAMPLE_BITS-1:0]   line_store [TAP_COUNT][MAX_DELAY_FRAMES][NUM_CH];

  frame_job_t frames_to_send [$];
  echo_out_t  echo_due [$];
  int         mismatches;
  bit         calm_run;

  // Clock, and every block input at a known value from time zero.
  initial begin
    clk              = 1'b0;
    rst_n            = 1'b0;
    frame_ch.valid     = 1'b0;
    frame_ch.left_in   = '0;
    frame_ch.right_in  = '0;
    frame_ch.block_end = 1'b0;
    result_ch.ready  = 1'b0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = REG_TAP_GAINS;
    cfg_ch.data      = '0;
    tap_gain_word    = '0;
    feedback_q14     = '0;
    mismatches       = 0;
    calm_run         = 1'b0;
    for (int k = 0; k < TAP_COUNT; k++) begin
      line_len_reg[k] = DELAY_REG_W'(DELAY_RESET);
      line_ptr[k]     = '0;
    end
    forever #5 clk = ~clk;
  end

  // Run limit, far above the slowest legal run.
  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // Saturate a wide value to one sample and note when it clips.
  function automatic logic signed [SAMPLE_BITS-1:0] clamp_sample(input longint v,
                                                                 inout logic hit);
    if (v > SAT_MAX) begin
      hit = 1'b1;
      return SAMPLE_BITS'(SAT_MAX);
    end
    if (v < SAT_MIN) begin
      hit = 1'b1;
      return SAMPLE_BITS'(SAT_MIN);
    end
    return v[SAMPLE_BITS-1:0];
  endfunction

  // Compute the echoed frame, write the feedback value into every line and
  // advance the pointers.
  function automatic echo_out_t echo_frame(input frame_t f);
    longint                        tap_sum [NUM_CH];
    longint                        sample;
    logic signed [SAMPLE_BITS-1:0] mixed [NUM_CH];
    logic signed [SAMPLE_BITS-1:0] fed [NUM_CH];
    logic signed [GAIN_BITS-1:0]   gain;
    int                            span;
    int                            step;
    logic                          hit;
    echo_out_t                     r;
    hit = 1'b0;
    for (int c = 0; c < NUM_CH; c++) tap_sum[c] = '0;
    // Exact sum of all tap products per channel.
    for (int k = 0; k < TAP_COUNT; k++) begin
      gain = tap_gain_word[GAIN_BITS*k +: GAIN_BITS];
      for (int c = 0; c < NUM_CH; c++)
        tap_sum[c] += longint'(line_store[k][line_ptr[k]][c]) * longint'(gain);
    end
    // Output and feedback value, both rounded half up and saturated.
    for (int c = 0; c < NUM_CH; c++) begin
      sample   = (c == 0) ? longint'(f.left) : longint'(f.right);
      mixed[c] = clamp_sample(sample +
                   ((tap_sum[c] + (longint'(1) <<< (OUT_FRAC - 1))) >>> OUT_FRAC), hit);
      fed[c]   = clamp_sample(sample +
                   ((longint'(feedback_q14) * tap_sum[c] +
                     (longint'(1) <<< (FB_FRAC - 1))) >>> FB_FRAC), hit);
    end
    // Write back and step each pointer; zero length acts as one frame and
    // lengths beyond the memory act as the full memory.
    for (int k = 0; k < TAP_COUNT; k++) begin
      for (int c = 0; c < NUM_CH; c++) line_store[k][line_ptr[k]][c] = fed[c];
      if (line_len_reg[k] == '0)
        span = 1;
      else if (int'(line_len_reg[k]) > MAX_DELAY_FRAMES)
        span = MAX_DELAY_FRAMES;
      else
        span = int'(line_len_reg[k]);
      step = int'(line_ptr[k]) + 1;
      line_ptr[k] = (step >= span) ? '0 : step[ADDR_W-1:0];
    end
    r.left      = mixed[0];
    r.right     = mixed[1];
    r.clipped   = hit;
    r.block_end = f.block_end;
    return r;
  endfunction

  // Register write as the predictor sees it.
  function automatic void store_register(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] value);
    int k;
    case (idx)
      REG_TAP_GAINS: tap_gain_word = value[GAIN_REG_W-1:0];
      REG_FEEDBACK:  feedback_q14  = value[GAIN_BITS-1:0];
      REG_DELAY_0, REG_DELAY_1, REG_DELAY_2, REG_DELAY_3: begin
        k = int'(idx) - int'(REG_DELAY_0);
        line_len_reg[k] = value[DELAY_REG_W-1:0];
        line_ptr[k]     = '0;
      end
      default: ;
    endcase
  endfunction

  // Mix of full-range, small and extreme samples.
  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
    int style;
    style = $urandom_range(99);
    if (style < 55) return SAMPLE_BITS'($urandom);
    if (style < 80) return SAMPLE_BITS'(int'($urandom_range(4000)) - 2000);
    case ($urandom_range(4))
      0:       return SAMPLE_BITS'(SAT_MAX);
      1:       return SAMPLE_BITS'(SAT_MIN);
      2:       return '0;
      3:       return SAMPLE_BITS'(1);
      default: return SAMPLE_BITS'(-1);
    endcase
  endfunction

  // Half the gains anywhere in range, half moderate so echoes stay audible.
  function automatic logic [GAIN_BITS-1:0] pick_gain();
    if ($urandom_range(1) == 0) return GAIN_BITS'($urandom);
    return GAIN_BITS'(int'($urandom_range(12288)) - 6144);
  endfunction

  // Mostly short lines, now and then a zero, full or oversized length.
  function automatic logic [CFG_DATA_W-1:0] pick_delay_word();
    logic [CFG_DATA_W-1:0] w;
    w = {$urandom, $urandom};
    case ($urandom_range(11))
      0:       w[15:0] = '0;
      1:       w[15:0] = 16'd1;
      2:       w[15:0] = 16'(MAX_DELAY_FRAMES);
      3:       w[15:0] = 16'hFFFF;
      4:       w[15:0] = 16'($urandom_range(MAX_DELAY_FRAMES + 1, MAX_DELAY_FRAMES - 1));
      default: w[15:0] = 16'($urandom_range(40, 1));
    endcase
    return w;
  endfunction

  function automatic int pick_idle_odds();
    case ($urandom_range(3))
      0, 1:    return 0;
      2:       return 10;
      default: return 35;
    endcase
  endfunction

  function automatic frame_job_t random_job(input bit force_drain);
    frame_job_t j;
    j.frame.left      = pick_sample();
    j.frame.right     = pick_sample();
    j.frame.block_end = 1'($urandom_range(1));
    j.drain_first     = force_drain || ($urandom_range(149) == 0);
    return j;
  endfunction

  function automatic void queue_frame(input int l, input int r, input bit e);
    frame_job_t j;
    j.frame.left      = l[SAMPLE_BITS-1:0];
    j.frame.right     = r[SAMPLE_BITS-1:0];
    j.frame.block_end = e;
    j.drain_first     = 1'b0;
    frames_to_send.push_back(j);
  endfunction

  // One configuration transfer; the predictor takes it at the same edge.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    store_register(idx, value);
  endtask

  // Fresh random settings; the first random phase writes every register.
  task automatic configure_random(input bit all_regs);
    logic [CFG_DATA_W-1:0] w;
    for (int r = REG_TAP_GAINS; r <= REG_DELAY_3; r++) begin
      if (all_regs || $urandom_range(3) != 0) begin
        w = {$urandom, $urandom};
        if (cfg_reg_e'(r) == REG_TAP_GAINS)
          w = {pick_gain(), pick_gain(), pick_gain(), pick_gain()};
        else if (cfg_reg_e'(r) == REG_FEEDBACK)
          w[GAIN_BITS-1:0] = pick_gain();
        else
          w = pick_delay_word();
        write_reg(cfg_reg_e'(r), w);
      end
    end
  endtask

  // Wait until every frame is sent and every result is back, then let the
  // engine finish its last write back.
  task automatic wait_quiet();
    do @(posedge clk);
    while (frames_to_send.size() != 0 || frame_ch.valid || echo_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Frame driver: predicts each transfer and offers the next frame unless an
  // idle burst or a drain hold is in progress.
  int         src_gap;
  int         src_idle_pct;
  int         src_cycles;
  frame_job_t frame_on_wire;

  always @(posedge clk) begin : frame_driver
    frame_job_t job;
    logic       launch;
    if (rst_n) begin
      if (frame_ch.valid && frame_ch.ready) echo_due.push_back(echo_frame(frame_on_wire.frame));
      src_cycles++;
      if (src_cycles % 200 == 1) src_idle_pct = pick_idle_odds();
      if (!frame_ch.valid || frame_ch.ready) begin
        launch = 1'b0;
        if (src_gap > 0) begin
          src_gap--;
        end else if (!calm_run && $urandom_range(99) < src_idle_pct) begin
          src_gap = $urandom_range(17, 1) - 1;
        end else if (frames_to_send.size() != 0 &&
                     !(frames_to_send[0].drain_first && echo_due.size() != 0)) begin
          job           = frames_to_send.pop_front();
          frame_on_wire = job;
          launch        = 1'b1;
          frame_ch.left_in   <= job.frame.left;
          frame_ch.right_in  <= job.frame.right;
          frame_ch.block_end <= job.frame.block_end;
        end
        frame_ch.valid <= launch;
      end
    end
  end

  // Result monitor: checks each transfer against the oldest expectation and
  // stalls the block in random bursts.
  int sink_gap;
  int sink_idle_pct;
  int sink_cycles;

  always @(posedge clk) begin : result_monitor
    echo_out_t got;
    echo_out_t want;
    logic      take;
    if (rst_n) begin
      if (result_ch.valid && result_ch.ready) begin
        got.left      = result_ch.left_out;
        got.right     = result_ch.right_out;
        got.clipped   = result_ch.clipped;
        got.block_end = result_ch.block_end_out;
        if (echo_due.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_CAP)
            $display("%0t: result with none expected: left %0d right %0d", $time,
                     got.left, got.right);
        end else begin
          want = echo_due.pop_front();
          if (got.left !== want.left || got.right !== want.right ||
              got.clipped !== want.clipped || got.block_end !== want.block_end) begin
            mismatches++;
            if (mismatches <= REPORT_CAP) begin
              $display("%0t: echo result mismatch", $time);
              $display("  expected left %0d right %0d clipped %0b end %0b",
                       want.left, want.right, want.clipped, want.block_end);
              $display("  actual   left %0d right %0d clipped %0b end %0b",
                       got.left, got.right, got.clipped, got.block_end);
            end
          end
        end
      end
      sink_cycles++;
      if (sink_cycles % 200 == 1) sink_idle_pct = pick_idle_odds();
      take = 1'b1;
      if (sink_gap > 0) begin
        sink_gap--;
        take = 1'b0;
      end else if (!calm_run && $urandom_range(99) < sink_idle_pct) begin
        sink_gap = $urandom_range(17, 1) - 1;
        take     = 1'b0;
      end
      result_ch.ready <= take;
    end
  end

  // Stimulus: reset, directed phases, random phases, final verdict.
  initial begin : stimulus
    src_gap       = 0;
    src_cycles    = 0;
    src_idle_pct  = 0;
    sink_gap      = 0;
    sink_cycles   = 0;
    sink_idle_pct = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Reset values: zero gains, so every frame comes back unchanged.
    @(negedge clk);
    queue_frame(SAT_MAX, SAT_MIN, 1'b1);
    queue_frame(SAT_MIN, SAT_MAX, 1'b0);
    queue_frame(0, 0, 1'b1);
    queue_frame(1, -1, 1'b0);
    queue_frame(-1, 1, 1'b1);
    queue_frame(int'(16'h5555), int'(16'hAAAA), 1'b0);
    wait_quiet();

    // Unity taps on very short lines with strong feedback: saturation in
    // both directions, then the echoes fed back from it. Spare indexes must be ignored.
    write_reg(REG_TAP_GAINS, 64'h4000_4000_4000_4000);
    write_reg(REG_FEEDBACK, {$urandom, 16'h0000, 16'h2000});
    write_reg(REG_DELAY_0, '0);
    write_reg(REG_DELAY_1, CFG_DATA_W'(1));
    write_reg(REG_DELAY_2, CFG_DATA_W'(2));
    write_reg(REG_DELAY_3, CFG_DATA_W'(3));
    write_reg(UNMAPPED_REG_LO, {$urandom, $urandom});
    write_reg(UNMAPPED_REG_HI, {$urandom, $urandom});
    @(negedge clk);
    queue_frame(SAT_MAX, SAT_MAX, 1'b0);
    queue_frame(SAT_MAX, SAT_MAX, 1'b1);
    queue_frame(SAT_MIN, SAT_MIN, 1'b1);
    queue_frame(SAT_MIN, SAT_MIN, 1'b0);
    queue_frame(0, 0, 1'b0);
    queue_frame(0, 0, 1'b1);
    queue_frame(0, 0, 1'b0);
    queue_frame(100, -100, 1'b1);
    queue_frame(1, 1, 1'b0);
    queue_frame(-1, -1, 1'b0);
    wait_quiet();

    // Smallest tap gain on a one-frame line: outputs land on the half-way
    // rounding points, which must round up in both signs.
    write_reg(REG_TAP_GAINS, 64'h0000_0000_0000_0001);
    write_reg(REG_FEEDBACK, CFG_DATA_W'(1));
    write_reg(REG_DELAY_0, CFG_DATA_W'(1));
    @(negedge clk);
    queue_frame(8192, -8192, 1'b0);
    queue_frame(-8192, 8192, 1'b0);
    queue_frame(8191, -8193, 1'b1);
    queue_frame(-8193, 8191, 1'b0);
    queue_frame(24576, -24576, 1'b0);
    queue_frame(-24576, 24576, 1'b1);
    queue_frame(0, 0, 1'b0);
    wait_quiet();

    // Random phases; two of them use the most extreme gains and lengths,
    // and the last one runs with no idling on either side.
    for (int ph = 0; ph < ROUNDS; ph++) begin
      if (ph == 4) begin
        write_reg(REG_TAP_GAINS, 64'h7FFF_7FFF_7FFF_7FFF);
        write_reg(REG_FEEDBACK, CFG_DATA_W'(16'h7FFF));
        write_reg(REG_DELAY_0, '0);
        write_reg(REG_DELAY_1, CFG_DATA_W'(MAX_DELAY_FRAMES));
        write_reg(REG_DELAY_2, CFG_DATA_W'(16'hFFFF));
        write_reg(REG_DELAY_3, CFG_DATA_W'(1));
      end else if (ph == 7) begin
        write_reg(REG_TAP_GAINS, 64'h8000_8000_8000_8000);
        write_reg(REG_FEEDBACK, CFG_DATA_W'(16'h8000));
        write_reg(REG_DELAY_0, CFG_DATA_W'(MAX_DELAY_FRAMES - 1));
        write_reg(REG_DELAY_1, CFG_DATA_W'(MAX_DELAY_FRAMES + 1));
        write_reg(REG_DELAY_2, CFG_DATA_W'(2));
        write_reg(REG_DELAY_3, CFG_DATA_W'(1));
      end else begin
        configure_random(ph == 0);
      end
      if (ph == ROUNDS - 1) calm_run = 1'b1;
      @(negedge clk);
      for (int i = 0; i < PER_ROUND; i++)
        frames_to_send.push_back(random_job(i == PER_ROUND / 2));
      wait_quiet();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && echo_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/fte_pkg.sv
rtl/fte_frame_if.sv
rtl/fte_result_if.sv
rtl/fte_cfg_if.sv
rtl/fte_echo_ram.sv
rtl/fte_in_queue.sv
rtl/fte_engine.sv
rtl/four_tap_feedback_echo.sv
sim/four_tap_feedback_echo_test.sv
